>>> sv/pobs_pkg.sv
// shared types and constants for the pulse oximetry beat and spo2 block
package pobs_pkg;

  localparam int SMOOTH_TAPS  = 5;
  localparam int RATE_ENTRIES = 4;
  localparam int WINDOW_DEPTH = 100;

  localparam int RAW_W    = 24;
  localparam int SAMPLE_W = 18;
  localparam int TIME_W   = 32;
  localparam int THR_W    = 10;
  localparam int IVL_W    = 16;
  localparam int BEATS_W  = 4;
  localparam int BPM_W    = 8;
  localparam int SPO2_W   = 10;
  localparam int SLOPE_W  = 20;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 18;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_FINGER_THR = 3'd0,
    REG_SLOPE_THR  = 3'd1,
    REG_BEAT_MIN   = 3'd2,
    REG_IVL_MIN    = 3'd3,
    REG_IVL_MAX    = 3'd4,
    REG_MIN_BEATS  = 3'd5
  } reg_idx_t;

  localparam logic [SAMPLE_W-1:0] FINGER_THR_RST = 18'd50000;
  localparam logic [THR_W-1:0]    SLOPE_THR_RST  = 10'd20;
  localparam logic [SAMPLE_W-1:0] BEAT_MIN_RST   = 18'd100000;
  localparam logic [IVL_W-1:0]    IVL_MIN_RST    = 16'd350;
  localparam logic [IVL_W-1:0]    IVL_MAX_RST    = 16'd2500;
  localparam logic [BEATS_W-1:0]  MIN_BEATS_RST  = 4'd3;
  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX     = 18'h3FFFF;

  // moving average: divide by taps through a reciprocal multiply
  localparam int SM_PW    = $clog2(SMOOTH_TAPS);
  localparam int SM_SUM_W = SAMPLE_W + $clog2(SMOOTH_TAPS);
  localparam int SM_SHIFT = SM_SUM_W + $clog2(SMOOTH_TAPS);
  localparam logic [SM_SHIFT-1:0] SM_RECIP =
    SM_SHIFT'(((64'd1 << SM_SHIFT) + 64'(SMOOTH_TAPS) - 64'd1) / 64'(SMOOTH_TAPS));

  localparam int RATE_PW    = (RATE_ENTRIES > 1) ? $clog2(RATE_ENTRIES) : 1;
  localparam int RATE_CW    = $clog2(RATE_ENTRIES + 1);
  localparam int RATE_ACC_W = BPM_W + RATE_CW;

  localparam int WIN_AW    = $clog2(WINDOW_DEPTH);
  localparam int WIN_SUM_W = SAMPLE_W + $clog2(WINDOW_DEPTH);
  localparam int PROD_W    = SAMPLE_W + WIN_SUM_W;
  localparam int WIN_DW    = 2 * SAMPLE_W;

  // shared serial divider
  localparam int DIV_W   = PROD_W + 9;
  localparam int DEN_W   = PROD_W;
  localparam int DIV_SW  = $clog2(DIV_W + 1);
  localparam int SHORT_W = 16;

  localparam logic [SHORT_W-1:0] MS_PER_MIN = 16'd60000;
  localparam logic [BPM_W-1:0]   BPM_LOW    = 8'd40;
  localparam logic [BPM_W-1:0]   BPM_HIGH   = 8'd180;

  // spo2 tenths = 1040 - ceil(170 * num / den)
  localparam int SPO2_BASE = 1040;
  localparam int SPO2_GAIN = 170;
  localparam int SPO2_FULL = 1000;
  localparam int SPO2_MIN  = 700;
  localparam logic [DIV_W-1:0] SPO2_C_HI = DIV_W'(SPO2_BASE - SPO2_MIN);
  localparam logic [DIV_W-1:0] SPO2_C_LO = DIV_W'(SPO2_BASE - SPO2_FULL);

  typedef struct packed {
    logic              start;
    logic [DIV_SW-1:0] steps;
  } div_ctl_t;

endpackage

>>> sv/pobs_if.sv
// channel interfaces: sample input, result output, register writes
interface pobs_smp_if;
  logic                           valid;
  logic                           ready;
  logic [pobs_pkg::RAW_W-1:0]     red_word;
  logic [pobs_pkg::RAW_W-1:0]     ir_word;
  logic [pobs_pkg::TIME_W-1:0]    time_ms;
  modport source (output valid, red_word, ir_word, time_ms, input ready);
  modport sink (input valid, red_word, ir_word, time_ms, output ready);
endinterface

interface pobs_res_if;
  logic                           valid;
  logic                           ready;
  logic                           finger_present;
  logic                           beat_seen;
  logic [pobs_pkg::BPM_W-1:0]     bpm_average;
  logic [pobs_pkg::SPO2_W-1:0]    spo2_tenths;
  logic                           spo2_valid;
  modport source (output valid, finger_present, beat_seen, bpm_average, spo2_tenths,
                  spo2_valid, input ready);
  modport sink (input valid, finger_present, beat_seen, bpm_average, spo2_tenths,
                spo2_valid, output ready);
endinterface

interface pobs_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [pobs_pkg::CFG_ADDR_W-1:0]  addr;
  logic [pobs_pkg::CFG_DATA_W-1:0]  data;
  modport source (output valid, addr, data, input ready);
  modport sink (input valid, addr, data, output ready);
endinterface

>>> sv/pobs_ram.sv
// generic single write port ram with registered read
module pobs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/pobs_div.sv
// restoring divider, one quotient bit per cycle, numerator taken msb first
module pobs_div (
  input  logic                           clk,
  input  logic                           rst,
  input  pobs_pkg::div_ctl_t             ctl,
  input  logic [pobs_pkg::DIV_W-1:0]     numer,
  input  logic [pobs_pkg::DEN_W-1:0]     denom,
  output logic                           done,
  output logic [pobs_pkg::DIV_W-1:0]     quot
);

  logic                          busy;
  logic [pobs_pkg::DIV_SW-1:0]   cnt;
  logic [pobs_pkg::DIV_W-1:0]    num_sh;
  logic [pobs_pkg::DEN_W-1:0]    rem;
  logic [pobs_pkg::DEN_W-1:0]    den;
  logic [pobs_pkg::DEN_W:0]      rem_sh;
  logic [pobs_pkg::DEN_W:0]      rem_next;
  logic                          fits;

  always_comb begin
    rem_sh   = {rem, num_sh[pobs_pkg::DIV_W-1]};
    fits     = rem_sh >= {1'b0, den};
    rem_next = fits ? rem_sh - {1'b0, den} : rem_sh;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy   <= 1'b1;
        cnt    <= ctl.steps;
        num_sh <= numer;
        rem    <= '0;
        den    <= denom;
        quot   <= '0;
      end else if (busy) begin
        num_sh <= num_sh << 1;
        rem    <= rem_next[pobs_pkg::DEN_W-1:0];
        quot   <= {quot[pobs_pkg::DIV_W-2:0], fits};
        cnt    <= cnt - 1'b1;
        if (cnt == pobs_pkg::DIV_SW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> sv/pulse_oximetry_beat_and_spo2.sv
// Pulse oximetry beat detector and SpO2 estimator. One result item per sample item.
// A sample is taken only while the block is idle and its previous result is in the output register.
// From one accepted sample to the next: a sample with no finger goes straight to its result; an
// ordinary sample passes the sum, smooth, beat and window states; a beat with an accepted interval
// adds two 16-step divisions; once the window is full and enough beats are counted, a sweep of
// the red/IR window memory (one entry per cycle), the products and a DIV_W-step ratio division
// follow before the result is handed to the output register.
// The window memory needs no clearing pass: a fill count marks which entries hold data.
module pulse_oximetry_beat_and_spo2 (
  input  logic         clk,
  input  logic         rst,
  pobs_cfg_if.sink     cfg,
  pobs_smp_if.sink     smp,
  pobs_res_if.source   res
);

  typedef enum logic [10:0] {
    S_IDLE   = 11'b00000000001,
    S_SUM    = 11'b00000000010,
    S_SMOOTH = 11'b00000000100,
    S_BEAT   = 11'b00000001000,
    S_BPMDIV = 11'b00000010000,
    S_RATE   = 11'b00000100000,
    S_AVGDIV = 11'b00001000000,
    S_WIN    = 11'b00010000000,
    S_SCAN   = 11'b00100000000,
    S_MUL    = 11'b01000000000,
    S_SPDIV  = 11'b10000000000
  } st_t;

  st_t st;
  logic done_pend;

  // configuration
  logic [pobs_pkg::SAMPLE_W-1:0] finger_thr;
  logic [pobs_pkg::THR_W-1:0]    slope_thr;
  logic [pobs_pkg::SAMPLE_W-1:0] beat_min;
  logic [pobs_pkg::IVL_W-1:0]    ivl_min;
  logic [pobs_pkg::IVL_W-1:0]    ivl_max;
  logic [pobs_pkg::BEATS_W-1:0]  min_beats;

  // current item
  logic [pobs_pkg::SAMPLE_W-1:0] red_r;
  logic [pobs_pkg::SAMPLE_W-1:0] ir_r;
  logic [pobs_pkg::TIME_W-1:0]   now_r;
  logic                          finger_r;
  logic                          beat_r;

  // running state
  logic [pobs_pkg::SAMPLE_W-1:0]  smooth_ring [pobs_pkg::SMOOTH_TAPS];
  logic [pobs_pkg::SM_PW-1:0]     smooth_pos;
  logic [pobs_pkg::SM_SUM_W-1:0]  sm_sum;
  logic [pobs_pkg::SAMPLE_W-1:0]  smooth_r;
  logic [pobs_pkg::SAMPLE_W-1:0]  last_smooth;
  logic signed [pobs_pkg::SLOPE_W-1:0] last_slope;
  logic [pobs_pkg::TIME_W-1:0]    last_beat_time;
  logic [pobs_pkg::BPM_W-1:0]     rate_ring [pobs_pkg::RATE_ENTRIES];
  logic [pobs_pkg::RATE_PW-1:0]   rate_pos;
  logic [pobs_pkg::BEATS_W-1:0]   beat_total;
  logic [pobs_pkg::BPM_W-1:0]     bpm_held;
  logic [pobs_pkg::WIN_AW-1:0]    window_pos;
  logic                           window_full;
  logic [pobs_pkg::SPO2_W-1:0]    spo2_held;

  // window sweep
  logic                           scan_on;
  logic [pobs_pkg::WIN_AW-1:0]    scan_addr;
  logic                           rd_vld;
  logic                           rd_last;
  logic [pobs_pkg::WIN_DW-1:0]    rd_data;
  logic [pobs_pkg::SAMPLE_W-1:0]  rd_ir;
  logic [pobs_pkg::SAMPLE_W-1:0]  rd_red;
  logic [pobs_pkg::SAMPLE_W-1:0]  ir_max, ir_min, red_max, red_min;
  logic [pobs_pkg::WIN_SUM_W-1:0] ir_sum, red_sum;
  logic [pobs_pkg::PROD_W-1:0]    num_r, den_r;
  logic                           mul_go;

  // divider
  pobs_pkg::div_ctl_t             div_ctl;
  logic [pobs_pkg::DIV_W-1:0]     div_numer;
  logic [pobs_pkg::DEN_W-1:0]     div_denom;
  logic                           div_done;
  logic [pobs_pkg::DIV_W-1:0]     div_quot;

  // combinational helpers
  logic [pobs_pkg::SAMPLE_W-1:0]  ir_in;
  logic [pobs_pkg::SM_SUM_W+pobs_pkg::SM_SHIFT-1:0] sm_prod;
  logic signed [pobs_pkg::SLOPE_W-1:0] slope, thr_s;
  logic                           peak;
  logic [pobs_pkg::TIME_W-1:0]    gap;
  logic                           gap_ok;
  logic [pobs_pkg::RATE_ACC_W-1:0] rate_acc;
  logic [pobs_pkg::RATE_CW-1:0]   rate_cnt;
  logic [pobs_pkg::BPM_W-1:0]     bpm_q;
  logic                           bpm_ok;
  logic                           win_last;
  logic                           full_next;
  logic                           degenerate;
  logic [pobs_pkg::DIV_W-1:0]     spo2_numer;
  logic [pobs_pkg::SPO2_W-1:0]    spo2_calc;
  logic                           res_load;

  function automatic logic [pobs_pkg::SM_SUM_W-1:0] tap_sum(
    input logic [pobs_pkg::SAMPLE_W-1:0] taps [pobs_pkg::SMOOTH_TAPS]
  );
    logic [pobs_pkg::SM_SUM_W-1:0] acc;
    acc = '0;
    for (int i = 0; i < pobs_pkg::SMOOTH_TAPS; i++) begin
      acc = acc + pobs_pkg::SM_SUM_W'(taps[i]);
    end
    return acc;
  endfunction

  assign ir_in     = smp.ir_word[pobs_pkg::SAMPLE_W-1:0];
  assign smp.ready = (st == S_IDLE) && !done_pend && !rst;
  assign cfg.ready = !rst;
  assign res_load  = done_pend && (!res.valid || res.ready);

  always_comb begin
    sm_prod  = (pobs_pkg::SM_SUM_W + pobs_pkg::SM_SHIFT)'(sm_sum) *
               (pobs_pkg::SM_SUM_W + pobs_pkg::SM_SHIFT)'(pobs_pkg::SM_RECIP);
    slope    = $signed(pobs_pkg::SLOPE_W'(smooth_r)) - $signed(pobs_pkg::SLOPE_W'(last_smooth));
    thr_s    = $signed(pobs_pkg::SLOPE_W'(slope_thr));
    peak     = (last_slope > thr_s) && (slope < -thr_s) && (smooth_r > beat_min);
    gap      = now_r - last_beat_time;
    gap_ok   = (gap > pobs_pkg::TIME_W'(ivl_min)) && (gap < pobs_pkg::TIME_W'(ivl_max)) &&
               (last_beat_time != '0);
    bpm_q    = div_quot[pobs_pkg::BPM_W-1:0];
    bpm_ok   = (div_quot[pobs_pkg::SHORT_W-1:0] >= pobs_pkg::SHORT_W'(pobs_pkg::BPM_LOW)) &&
               (div_quot[pobs_pkg::SHORT_W-1:0] <= pobs_pkg::SHORT_W'(pobs_pkg::BPM_HIGH));
    win_last = window_pos == pobs_pkg::WIN_AW'(pobs_pkg::WINDOW_DEPTH - 1);
    full_next = window_full || win_last;
    rd_ir    = rd_data[pobs_pkg::SAMPLE_W-1:0];
    rd_red   = rd_data[pobs_pkg::WIN_DW-1:pobs_pkg::SAMPLE_W];
    degenerate = (ir_sum == '0) || (red_sum == '0) || (ir_max == ir_min);
    spo2_numer = pobs_pkg::DIV_W'(num_r) * pobs_pkg::DIV_W'(pobs_pkg::SPO2_GAIN) +
                 pobs_pkg::DIV_W'(den_r) - pobs_pkg::DIV_W'(1);
    rate_acc = '0;
    rate_cnt = '0;
    for (int i = 0; i < pobs_pkg::RATE_ENTRIES; i++) begin
      if (rate_ring[i] != '0) begin
        rate_acc = rate_acc + pobs_pkg::RATE_ACC_W'(rate_ring[i]);
        rate_cnt = rate_cnt + 1'b1;
      end
    end
    if (div_quot > pobs_pkg::SPO2_C_HI) begin
      spo2_calc = '0;
    end else if (div_quot < pobs_pkg::SPO2_C_LO) begin
      spo2_calc = pobs_pkg::SPO2_W'(pobs_pkg::SPO2_FULL);
    end else begin
      spo2_calc = pobs_pkg::SPO2_W'(pobs_pkg::SPO2_BASE) -
                  div_quot[pobs_pkg::SPO2_W-1:0];
    end
  end

  // divider requests
  always_comb begin
    div_ctl   = '0;
    div_numer = '0;
    div_denom = '0;
    case (st)
      S_BEAT: begin
        div_ctl.start = peak && gap_ok;
        div_ctl.steps = pobs_pkg::DIV_SW'(pobs_pkg::SHORT_W);
        div_numer = {pobs_pkg::MS_PER_MIN, {(pobs_pkg::DIV_W - pobs_pkg::SHORT_W){1'b0}}};
        div_denom = pobs_pkg::DEN_W'(gap[pobs_pkg::SHORT_W-1:0]);
      end
      S_RATE: begin
        div_ctl.start = 1'b1;
        div_ctl.steps = pobs_pkg::DIV_SW'(pobs_pkg::SHORT_W);
        div_numer = {pobs_pkg::SHORT_W'(rate_acc),
                     {(pobs_pkg::DIV_W - pobs_pkg::SHORT_W){1'b0}}};
        div_denom = pobs_pkg::DEN_W'(rate_cnt);
      end
      S_MUL: begin
        div_ctl.start = mul_go;
        div_ctl.steps = pobs_pkg::DIV_SW'(pobs_pkg::DIV_W);
        div_numer = spo2_numer;
        div_denom = den_r;
      end
      default: begin
        div_ctl = '0;
      end
    endcase
  end

  pobs_div u_div (
    .clk   (clk),
    .rst   (rst),
    .ctl   (div_ctl),
    .numer (div_numer),
    .denom (div_denom),
    .done  (div_done),
    .quot  (div_quot)
  );

  pobs_ram #(
    .WIDTH (pobs_pkg::WIN_DW),
    .DEPTH (pobs_pkg::WINDOW_DEPTH)
  ) u_win (
    .clk   (clk),
    .we    (st == S_WIN),
    .waddr (window_pos),
    .wdata ({red_r, ir_r}),
    .raddr (scan_addr),
    .rdata (rd_data)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      finger_thr <= pobs_pkg::FINGER_THR_RST;
      slope_thr  <= pobs_pkg::SLOPE_THR_RST;
      beat_min   <= pobs_pkg::BEAT_MIN_RST;
      ivl_min    <= pobs_pkg::IVL_MIN_RST;
      ivl_max    <= pobs_pkg::IVL_MAX_RST;
      min_beats  <= pobs_pkg::MIN_BEATS_RST;
    end else if (cfg.valid) begin
      case (pobs_pkg::reg_idx_t'(cfg.addr))
        pobs_pkg::REG_FINGER_THR: finger_thr <= cfg.data;
        pobs_pkg::REG_SLOPE_THR:  slope_thr  <= cfg.data[pobs_pkg::THR_W-1:0];
        pobs_pkg::REG_BEAT_MIN:   beat_min   <= cfg.data;
        pobs_pkg::REG_IVL_MIN:    ivl_min    <= cfg.data[pobs_pkg::IVL_W-1:0];
        pobs_pkg::REG_IVL_MAX:    ivl_max    <= cfg.data[pobs_pkg::IVL_W-1:0];
        pobs_pkg::REG_MIN_BEATS:  min_beats  <= cfg.data[pobs_pkg::BEATS_W-1:0];
        default: ;
      endcase
    end
  end

  // window sweep address and read tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_on <= 1'b0;
      rd_vld  <= 1'b0;
      rd_last <= 1'b0;
    end else begin
      rd_vld  <= scan_on;
      rd_last <= scan_on && (scan_addr == pobs_pkg::WIN_AW'(pobs_pkg::WINDOW_DEPTH - 1));
      if (st == S_WIN) begin
        scan_on   <= full_next && (beat_total >= min_beats);
        scan_addr <= '0;
      end else if (scan_on) begin
        if (scan_addr == pobs_pkg::WIN_AW'(pobs_pkg::WINDOW_DEPTH - 1)) begin
          scan_on <= 1'b0;
        end else begin
          scan_addr <= scan_addr + 1'b1;
        end
      end
    end
  end

  // main sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      st             <= S_IDLE;
      done_pend      <= 1'b0;
      mul_go         <= 1'b0;
      smooth_pos     <= '0;
      last_smooth    <= '0;
      last_slope     <= '0;
      last_beat_time <= '0;
      rate_pos       <= '0;
      beat_total     <= '0;
      bpm_held       <= '0;
      window_pos     <= '0;
      window_full    <= 1'b0;
      spo2_held      <= '0;
      for (int i = 0; i < pobs_pkg::SMOOTH_TAPS; i++) smooth_ring[i] <= '0;
      for (int i = 0; i < pobs_pkg::RATE_ENTRIES; i++) rate_ring[i] <= '0;
    end else begin
      mul_go <= 1'b0;
      if (res_load) begin
        done_pend <= 1'b0;
      end
      case (st)
        S_IDLE: begin
          if (smp.valid && smp.ready) begin
            red_r    <= smp.red_word[pobs_pkg::SAMPLE_W-1:0];
            ir_r     <= ir_in;
            now_r    <= smp.time_ms;
            beat_r   <= 1'b0;
            if (ir_in < finger_thr) begin
              // no finger: drop the beat, rate, window and spo2 statistics and the smoothing taps
              finger_r       <= 1'b0;
              last_beat_time <= '0;
              rate_pos       <= '0;
              beat_total     <= '0;
              bpm_held       <= '0;
              window_pos     <= '0;
              window_full    <= 1'b0;
              spo2_held      <= '0;
              for (int i = 0; i < pobs_pkg::SMOOTH_TAPS; i++) smooth_ring[i] <= '0;
              for (int i = 0; i < pobs_pkg::RATE_ENTRIES; i++) rate_ring[i] <= '0;
              done_pend <= 1'b1;
            end else begin
              finger_r                <= 1'b1;
              smooth_ring[smooth_pos] <= ir_in;
              smooth_pos <= (smooth_pos == pobs_pkg::SM_PW'(pobs_pkg::SMOOTH_TAPS - 1)) ?
                            '0 : smooth_pos + 1'b1;
              st <= S_SUM;
            end
          end
        end
        S_SUM: begin
          // the tap sum is formed from the ring registers
          sm_sum <= tap_sum(smooth_ring);
          st     <= S_SMOOTH;
        end
        S_SMOOTH: begin
          smooth_r <= sm_prod[pobs_pkg::SM_SHIFT +: pobs_pkg::SAMPLE_W];
          st       <= S_BEAT;
        end
        S_BEAT: begin
          last_slope  <= slope;
          last_smooth <= smooth_r;
          if (peak) begin
            beat_r         <= 1'b1;
            last_beat_time <= now_r;
          end
          st <= (peak && gap_ok) ? S_BPMDIV : S_WIN;
        end
        S_BPMDIV: begin
          if (div_done) begin
            if (bpm_ok) begin
              rate_ring[rate_pos] <= bpm_q;
              rate_pos <= (rate_pos == pobs_pkg::RATE_PW'(pobs_pkg::RATE_ENTRIES - 1)) ?
                          '0 : rate_pos + 1'b1;
              if (beat_total != '1) begin
                beat_total <= beat_total + 1'b1;
              end
              st <= S_RATE;
            end else begin
              st <= S_WIN;
            end
          end
        end
        S_RATE: begin
          st <= S_AVGDIV;
        end
        S_AVGDIV: begin
          if (div_done) begin
            bpm_held <= bpm_q;
            st       <= S_WIN;
          end
        end
        S_WIN: begin
          window_pos <= win_last ? '0 : window_pos + 1'b1;
          if (win_last) begin
            window_full <= 1'b1;
          end
          ir_max  <= '0;
          ir_min  <= pobs_pkg::SAMPLE_MAX;
          red_max <= '0;
          red_min <= pobs_pkg::SAMPLE_MAX;
          ir_sum  <= '0;
          red_sum <= '0;
          if (full_next && (beat_total >= min_beats)) begin
            st <= S_SCAN;
          end else begin
            done_pend <= 1'b1;
            st        <= S_IDLE;
          end
        end
        S_SCAN: begin
          if (rd_vld) begin
            if (rd_ir > ir_max) ir_max <= rd_ir;
            if (rd_ir < ir_min) ir_min <= rd_ir;
            if (rd_red > red_max) red_max <= rd_red;
            if (rd_red < red_min) red_min <= rd_red;
            ir_sum  <= ir_sum + pobs_pkg::WIN_SUM_W'(rd_ir);
            red_sum <= red_sum + pobs_pkg::WIN_SUM_W'(rd_red);
          end
          if (rd_last) begin
            st <= S_MUL;
          end
        end
        S_MUL: begin
          // the products are registered first, and mul_go then starts the division from them
          if (!mul_go) begin
            if (degenerate) begin
              done_pend <= 1'b1;
              st        <= S_IDLE;
            end else begin
              num_r  <= pobs_pkg::PROD_W'(red_max - red_min) * pobs_pkg::PROD_W'(ir_sum);
              den_r  <= pobs_pkg::PROD_W'(ir_max - ir_min) * pobs_pkg::PROD_W'(red_sum);
              mul_go <= 1'b1;
            end
          end else begin
            st <= S_SPDIV;
          end
        end
        S_SPDIV: begin
          if (div_done) begin
            spo2_held <= spo2_calc;
            done_pend <= 1'b1;
            st        <= S_IDLE;
          end
        end
        default: begin
          st <= S_IDLE;
        end
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (res_load) begin
      res.valid          <= 1'b1;
      res.finger_present <= finger_r;
      res.beat_seen      <= beat_r;
      res.bpm_average    <= bpm_held;
      res.spo2_tenths    <= spo2_held;
      res.spo2_valid     <= spo2_held >= pobs_pkg::SPO2_W'(pobs_pkg::SPO2_MIN);
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

endmodule

>>> sv/pobs_checker.sv
// port level checks for the pulse oximetry block, bound to the top level
module pobs_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic                            finger_present,
  input logic                            beat_seen,
  input logic [pobs_pkg::BPM_W-1:0]      bpm_average,
  input logic [pobs_pkg::SPO2_W-1:0]     spo2_tenths,
  input logic                            spo2_valid
);

  // one item at a time: after an item is taken the input closes
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input stayed open after an item");

  // a stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(spo2_tenths) && $stable(bpm_average))
    else $error("stalled result changed");

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> spo2_valid == (spo2_tenths >= pobs_pkg::SPO2_W'(pobs_pkg::SPO2_MIN)))
    else $error("spo2 valid flag disagrees with value");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && !finger_present |-> !beat_seen && bpm_average == '0 && spo2_tenths == '0)
    else $error("no finger item carries statistics");

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> spo2_tenths <= pobs_pkg::SPO2_W'(pobs_pkg::SPO2_FULL))
    else $error("spo2 above full scale");

endmodule

bind pulse_oximetry_beat_and_spo2 pobs_checker u_pobs_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (smp.valid),
  .in_ready       (smp.ready),
  .out_valid      (res.valid),
  .out_ready      (res.ready),
  .finger_present (res.finger_present),
  .beat_seen      (res.beat_seen),
  .bpm_average    (res.bpm_average),
  .spo2_tenths    (res.spo2_tenths),
  .spo2_valid     (res.spo2_valid)
);
